### rtl/core/jas_pkg.sv
// ----------------------------------------------------------------------------
// jas_pkg: shared types and constants
// Phase codes, status codes, result word layout and byte constants used by
// the APP1 segment stripper.
// ----------------------------------------------------------------------------
package jas_pkg;

    localparam logic [7:0]  BYTE_FF      = 8'hFF;
    localparam logic [7:0]  BYTE_SOI     = 8'hD8;
    localparam logic [7:0]  MARKER_RESET = 8'hE1;
    localparam logic [15:0] MIN_LENGTH   = 16'd2;
    localparam int          FIFO_DEPTH   = 4;

    typedef enum logic [2:0] {
        PH_START0 = 3'd0,
        PH_START1 = 3'd1,
        PH_SCAN   = 3'd2,
        PH_LENHI  = 3'd3,
        PH_LENLO  = 3'd4,
        PH_SKIP   = 3'd5,
        PH_PASS   = 3'd6,
        PH_DROP   = 3'd7
    } jas_phase_t;

    typedef enum logic [2:0] {
        ST_PROGRESS  = 3'd0,
        ST_REMOVED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_NOT_JPEG  = 3'd3,
        ST_TRUNCATED = 3'd4
    } jas_status_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_present;
        logic        end_of_stream;
        jas_status_t status;
        logic [31:0] found_offset;
        logic [15:0] found_length;
    } jas_result_t;

    // Up to two result words produced by one input word
    typedef struct packed {
        logic [1:0]        count;
        jas_result_t [1:0] item;
    } jas_push_t;

    function automatic jas_result_t jas_data_result(input logic [7:0] b);
        jas_result_t r;
        r              = '0;
        r.out_byte     = b;
        r.byte_present = 1'b1;
        r.status       = ST_PROGRESS;
        return r;
    endfunction

endpackage

### rtl/core/jas_if.sv
// ----------------------------------------------------------------------------
// jas_if: stream channels of the segment stripper
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface jas_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface jas_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_present;
    logic        end_of_stream;
    logic [2:0]  status;
    logic [31:0] found_offset;
    logic [15:0] found_length;

    modport source (
        output valid, output out_byte, output byte_present, output end_of_stream,
        output status, output found_offset, output found_length, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_present, input end_of_stream,
        input status, input found_offset, input found_length, output ready
    );
endinterface

### rtl/core/jas_parser.sv
// ----------------------------------------------------------------------------
// jas_parser: input register and marker parser
// Registers each input word, walks the file structure and emits up to two
// result words per byte into the result queue.
// ----------------------------------------------------------------------------
module jas_parser #(
    parameter int POSITION_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    jas_in_if.sink            in_ch,
    input  logic [7:0]        marker,
    input  logic              room,
    output jas_pkg::jas_push_t push
);
    import jas_pkg::*;

    logic                     in_valid_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_final_reg;
    logic                     fire;

    jas_phase_t               phase_reg, phase_next;
    logic                     held_ff_reg, held_ff_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] offset_reg, offset_next;
    logic [15:0]              length_reg, length_next;
    logic [15:0]              skip_reg, skip_next;

    logic [15:0]              len_v;
    logic [1:0]               cnt;
    jas_result_t [1:0]        res;
    jas_status_t              status_v;
    logic                     seg_v;

    function automatic logic [31:0] to_off32(input logic [POSITION_BITS-1:0] v);
        logic [POSITION_BITS+31:0] wide;
        wide = {32'b0, v};
        return wide[31:0];
    endfunction

    assign fire        = in_valid_reg && room;
    assign in_ch.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_byte_reg  <= in_ch.data_byte;
            in_final_reg <= in_ch.final_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START0;
            held_ff_reg <= 1'b0;
            pos_reg     <= '0;
            offset_reg  <= '0;
            length_reg  <= '0;
            skip_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            held_ff_reg <= held_ff_next;
            pos_reg     <= pos_next;
            offset_reg  <= offset_next;
            length_reg  <= length_next;
            skip_reg    <= skip_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        held_ff_next = held_ff_reg;
        pos_next     = pos_reg;
        offset_next  = offset_reg;
        length_next  = length_reg;
        skip_next    = skip_reg;
        len_v        = '0;
        cnt          = 2'd0;
        res          = '0;
        status_v     = ST_PROGRESS;
        seg_v        = 1'b0;

        if (fire)
        begin
            unique case (phase_reg)
                PH_START0:
                begin
                    phase_next = (in_byte_reg == BYTE_FF) ? PH_START1 : PH_DROP;
                end
                PH_START1:
                begin
                    if (in_byte_reg != BYTE_SOI)
                    begin
                        phase_next = PH_DROP;
                    end
                    else if (marker == BYTE_SOI)
                    begin
                        // start bytes themselves form the segment
                        offset_next = '0;
                        length_next = '0;
                        phase_next  = PH_LENHI;
                    end
                    else
                    begin
                        res[0]     = jas_data_result(BYTE_FF);
                        res[1]     = jas_data_result(in_byte_reg);
                        cnt        = 2'd2;
                        phase_next = PH_SCAN;
                    end
                end
                PH_SCAN:
                begin
                    if (held_ff_reg)
                    begin
                        if (in_byte_reg == marker)
                        begin
                            held_ff_next = 1'b0;
                            offset_next  = pos_reg - POSITION_BITS'(1);
                            length_next  = '0;
                            phase_next   = PH_LENHI;
                        end
                        else
                        begin
                            res[0] = jas_data_result(BYTE_FF);
                            cnt    = 2'd1;
                            if (in_byte_reg != BYTE_FF)
                            begin
                                res[1]       = jas_data_result(in_byte_reg);
                                cnt          = 2'd2;
                                held_ff_next = 1'b0;
                            end
                        end
                    end
                    else if (in_byte_reg == BYTE_FF)
                    begin
                        held_ff_next = 1'b1;
                    end
                    else
                    begin
                        res[0] = jas_data_result(in_byte_reg);
                        cnt    = 2'd1;
                    end
                end
                PH_LENHI:
                begin
                    length_next = {in_byte_reg, 8'h00};
                    phase_next  = PH_LENLO;
                end
                PH_LENLO:
                begin
                    len_v       = {length_reg[15:8], in_byte_reg};
                    length_next = len_v;
                    skip_next   = (len_v < MIN_LENGTH) ? 16'd0 : len_v - MIN_LENGTH;
                    phase_next  = (skip_next == 16'd0) ? PH_PASS : PH_SKIP;
                end
                PH_SKIP:
                begin
                    if (skip_reg != 16'd0)
                    begin
                        skip_next = skip_reg - 16'd1;
                    end
                    if (skip_next == 16'd0)
                    begin
                        phase_next = PH_PASS;
                    end
                end
                PH_PASS:
                begin
                    res[0] = jas_data_result(in_byte_reg);
                    cnt    = 2'd1;
                end
                PH_DROP:
                begin
                end
                default:
                begin
                end
            endcase

            if (in_final_reg)
            begin
                unique case (phase_next)
                    PH_SCAN:
                    begin
                        status_v = ST_NOT_FOUND;
                    end
                    PH_LENHI, PH_LENLO, PH_SKIP:
                    begin
                        status_v = ST_TRUNCATED;
                        seg_v    = 1'b1;
                    end
                    PH_PASS:
                    begin
                        status_v = ST_REMOVED;
                        seg_v    = 1'b1;
                    end
                    default:
                    begin
                        status_v = ST_NOT_JPEG;
                    end
                endcase

                // release a held FF before closing the file
                if (phase_next == PH_SCAN && held_ff_next)
                begin
                    res[cnt[0]] = jas_data_result(BYTE_FF);
                    cnt         = cnt + 2'd1;
                end
                if (cnt == 2'd0)
                begin
                    res[0] = '0;
                    cnt    = 2'd1;
                end
                res[cnt[1]].end_of_stream = 1'b1;
                res[cnt[1]].status        = status_v;
                res[cnt[1]].found_offset  = seg_v ? to_off32(offset_next) : 32'd0;
                res[cnt[1]].found_length  = seg_v ? length_next : 16'd0;

                phase_next   = PH_START0;
                held_ff_next = 1'b0;
                pos_next     = '0;
                offset_next  = '0;
                length_next  = '0;
                skip_next    = '0;
            end
            else
            begin
                pos_next = pos_reg + POSITION_BITS'(1);
            end
        end

        push.count = cnt;
        push.item  = res;
    end

endmodule

### rtl/core/jas_result_fifo.sv
// ----------------------------------------------------------------------------
// jas_result_fifo: result word queue
// Takes zero, one or two result words per cycle and hands out one per
// handshake on the output channel.
// ----------------------------------------------------------------------------
module jas_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  jas_pkg::jas_push_t push,
    output logic               room,
    jas_out_if.source          out_ch
);
    import jas_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    jas_result_t      mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_p1;
    logic             pop;
    jas_result_t      head;

    assign wr_ptr_p1 = wr_ptr_reg + PTR_W'(1);
    assign pop       = out_ch.valid && out_ch.ready;
    assign room      = count_reg <= CNT_W'(FIFO_DEPTH - 2);

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.item[0];
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_p1] <= push.item[1];
        end
    end

    assign head                 = mem_reg[rd_ptr_reg];
    assign out_ch.valid         = count_reg != '0;
    assign out_ch.out_byte      = head.out_byte;
    assign out_ch.byte_present  = head.byte_present;
    assign out_ch.end_of_stream = head.end_of_stream;
    assign out_ch.status        = head.status;
    assign out_ch.found_offset  = head.found_offset;
    assign out_ch.found_length  = head.found_length;

endmodule

### rtl/core/jpeg_app1_segment_stripper.sv
// ----------------------------------------------------------------------------
// jpeg_app1_segment_stripper: JPEG marker segment remover
// Streams a JPEG file in one byte per word and drops the first segment whose
// marker is FF followed by the marker byte register (E1 after reset), with its
// length field and payload; all other bytes pass through unchanged. Files that
// do not start with FF D8 produce no data. The last word of each file carries
// end_of_stream with the status and, if a segment was found, the FF's byte
// offset and the length field. Input bytes are taken at one per clock; a byte
// lands in the input register, is parsed from there once the queue has room,
// and its results are written to a four-word output queue, which offers them
// on the output channel. A byte can yield two words (a held FF released with
// the byte after it, the start bytes FF D8, or the end-of-file word), which the
// single output port drains one per cycle while the receiver is ready; the
// input stalls only while the queue holds more than two words.
// ----------------------------------------------------------------------------
module jpeg_app1_segment_stripper #(
    parameter int POSITION_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    jas_in_if.sink     in_ch,
    jas_out_if.source  out_ch,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data
);
    import jas_pkg::*;

    logic [7:0] marker_reg;
    logic       room;
    jas_push_t  push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= MARKER_RESET;
        end
        else if (cfg_we)
        begin
            marker_reg <= cfg_data;
        end
    end

    jas_parser #(
        .POSITION_BITS(POSITION_BITS)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .marker(marker_reg),
        .room  (room),
        .push  (push)
    );

    jas_result_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .out_ch(out_ch)
    );

`ifndef NO_ASSERTIONS
    // a status-only word only closes a file
    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.byte_present) |-> out_ch.end_of_stream)
        else $error("status-only word without end_of_stream");

    a_end_has_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.end_of_stream) |-> (out_ch.status != ST_PROGRESS))
        else $error("end_of_stream with in-progress status");

    a_mid_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.end_of_stream) |->
        (out_ch.status == ST_PROGRESS && out_ch.found_offset == 32'd0
         && out_ch.found_length == 16'd0))
        else $error("status fields set on a data word");

    // no data leaves a file rejected as not JPEG
    a_not_jpeg_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status == ST_NOT_JPEG) |->
        (!out_ch.byte_present && out_ch.found_length == 16'd0))
        else $error("data on a not-JPEG file");
`endif

endmodule
